// File: design/assert_macros.svh
// assertion macros shared by the byte rate tracker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define BRT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BRT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/brt_pkg.sv
// shared constants and types of the byte rate tracker
package brt_pkg;

   localparam int BUCKETS    = 64;
   localparam int PTR_W      = $clog2(BUCKETS);
   localparam int BUCKET_W   = 40;
   localparam int SUM_W      = BUCKET_W + PTR_W;
   localparam int RATE_W     = 43;
   localparam int TOTAL_W    = 63;
   localparam int FRAC_W     = 16;
   localparam int EWMA_W     = RATE_W + FRAC_W;
   localparam int WIN_W      = 7;
   localparam int ALPHA_W    = 17;
   localparam int COUNT_W    = 32;
   localparam int SECOND_W   = 32;
   localparam int DIV_N      = SUM_W + 3;
   localparam int DIV_CNT_W  = $clog2(DIV_N + 1);
   localparam int CMP_W      = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 2;
   localparam int PROD_W     = ALPHA_W + RATE_W;
   localparam int PROD_LO_W  = ALPHA_W + FRAC_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA  = 1'd1;

   localparam logic [WIN_W-1:0]    WINDOW_RESET = 7'd1;
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd6554;
   localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
   localparam logic [BUCKET_W-1:0] BUCKET_MAX   = {BUCKET_W{1'b1}};
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};

   typedef struct packed {
      logic signed [COUNT_W-1:0] byte_count;
      logic [SECOND_W-1:0]       now_second;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [RATE_W-1:0]  inst_rate;
      logic [RATE_W-1:0]  window_rate;
      logic [RATE_W-1:0]  ewma_rate;
      logic [RATE_W-1:0]  peak_rate;
      logic [TOTAL_W-1:0] byte_total;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic shift;
      logic add;
   } row_ctrl_type;

endpackage

// File: design/byte_rate_tracker_core.sv
// byte rate tracker top level: event sequencer, totals, ewma and result register
// sequence: a rejected event (negative count) goes from acceptance straight to the result register;
// an accepted event advances the ring (shifting the buckets one second per cycle when it moves on),
// adds to the head bucket, taps the window and runs the 49-step window divider
// one event in flight; the next is taken the cycle after the result is registered
// reset: synchronous, active high; clears all buckets, totals and rates
`include "assert_macros.svh"
module byte_rate_tracker_core import brt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADV   = 3'd1;
   localparam logic [2:0] ST_SHIFT = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_TAP   = 3'd4;
   localparam logic [2:0] ST_START = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [WIN_W-1:0]    window_ff, window_in;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [SECOND_W-1:0] bucket_second_ff, bucket_second_in;
   logic [PTR_W-1:0]    steps_ff, steps_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [RATE_W-1:0]   inst_ff, inst_in;
   logic [RATE_W-1:0]   win_rate_ff, win_rate_in;
   logic [RATE_W-1:0]   peak_ff, peak_in;
   logic [EWMA_W-1:0]   ewma_ff, ewma_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-2:0]   bytes_ff;
   logic [SECOND_W-1:0]  now_ff;
   logic                 neg_ff;
   logic [PROD_W-1:0]    prod_a_ff, prod_b_ff;
   logic [PROD_LO_W-1:0] prod_c_ff;
   rsp_type              rsp_ff;

   logic                 req_take;
   logic                 rsp_free;
   row_ctrl_type         row_ctrl;
   logic [BUCKET_W-1:0]  delta;
   logic [PTR_W-1:0]     tap;
   logic [SUM_W-1:0]     head_sum;
   logic [SUM_W-1:0]     tap_sum;
   logic                 div_start;
   logic                 div_busy;
   logic [DIV_N-1:0]     quotient;

   logic [WIN_W-1:0]     win_eff;
   logic [CMP_W-1:0]     win_ext;
   logic [ALPHA_W-1:0]   alpha_eff;
   logic [ALPHA_W-1:0]   keep;
   logic [SECOND_W-1:0]  sec_diff;
   logic [TOTAL_W:0]     total_sum;
   logic [BUCKET_W:0]    b0_sum;
   logic [BUCKET_W-1:0]  b0_new;
   logic [PROD_W:0]      ewma_sum;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // effective window, tap position and alpha
   always_comb begin
      win_eff   = (window_ff == '0) ? WIN_W'(1) : window_ff;
      win_ext   = CMP_W'(win_eff);
      if (win_ext >= CMP_W'(BUCKETS)) begin
         tap = PTR_W'(BUCKETS - 1);
      end else begin
         tap = PTR_W'(win_ext - CMP_W'(1));
      end
      alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      keep      = ALPHA_ONE - alpha_eff;
   end

   // arithmetic of the event
   always_comb begin
      sec_diff  = now_ff - bucket_second_ff;
      total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(bytes_ff);
      b0_sum    = {1'b0, head_sum[BUCKET_W-1:0]} + (BUCKET_W + 1)'(bytes_ff);
      b0_new    = b0_sum[BUCKET_W] ? BUCKET_MAX : b0_sum[BUCKET_W-1:0];
      delta     = b0_new - head_sum[BUCKET_W-1:0];
      ewma_sum  = (PROD_W + 1)'(prod_a_ff) + (PROD_W + 1)'(prod_b_ff)
                + (PROD_W + 1)'(prod_c_ff[PROD_LO_W-1:FRAC_W]);
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      bucket_second_in = bucket_second_ff;
      steps_in         = steps_ff;
      total_in         = total_ff;
      inst_in          = inst_ff;
      win_rate_in      = win_rate_ff;
      peak_in          = peak_ff;
      ewma_in          = ewma_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      row_ctrl         = '0;
      div_start        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_payload.byte_count[COUNT_W-1] ? ST_DONE : ST_ADV;
            end
         end
         ST_ADV: begin
            total_in         = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
            bucket_second_in = now_ff;
            state_in         = ST_ADD;
            if (now_ff != bucket_second_ff) begin
               if ((now_ff < bucket_second_ff) || (sec_diff >= SECOND_W'(BUCKETS))) begin
                  row_ctrl.clear = 1'b1;
               end else begin
                  row_ctrl.shift = 1'b1;
                  steps_in       = PTR_W'(sec_diff - SECOND_W'(1));
                  if (sec_diff != SECOND_W'(1)) begin
                     state_in = ST_SHIFT;
                  end
               end
            end
         end
         ST_SHIFT: begin
            row_ctrl.shift = 1'b1;
            steps_in       = steps_ff - 1'b1;
            if (steps_ff == PTR_W'(1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            row_ctrl.add = 1'b1;
            inst_in      = {b0_new, 3'b000};
            state_in     = ST_TAP;
         end
         ST_TAP: begin
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            ewma_in   = ewma_sum[EWMA_W-1:0];
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               win_rate_in = quotient[RATE_W-1:0];
               if (quotient[RATE_W-1:0] > peak_ff) begin
                  peak_in = quotient[RATE_W-1:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      window_in = window_ff;
      alpha_in  = alpha_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW: window_in = csr_data[WIN_W-1:0];
            REG_ALPHA:  alpha_in  = csr_data[ALPHA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_ff        <= WINDOW_RESET;
         alpha_ff         <= ALPHA_RESET;
         bucket_second_ff <= '0;
         steps_ff         <= '0;
         total_ff         <= '0;
         inst_ff          <= '0;
         win_rate_ff      <= '0;
         peak_ff          <= '0;
         ewma_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         window_ff        <= window_in;
         alpha_ff         <= alpha_in;
         bucket_second_ff <= bucket_second_in;
         steps_ff         <= steps_in;
         total_ff         <= total_in;
         inst_ff          <= inst_in;
         win_rate_ff      <= win_rate_in;
         peak_ff          <= peak_in;
         ewma_ff          <= ewma_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // transaction payload, ewma products and result register
   always_ff @(posedge clock) begin
      if (req_take) begin
         bytes_ff <= req_payload.byte_count[COUNT_W-2:0];
         now_ff   <= req_payload.now_second;
         neg_ff   <= req_payload.byte_count[COUNT_W-1];
      end
      if (state_ff == ST_TAP) begin
         prod_a_ff <= PROD_W'(alpha_eff) * PROD_W'(inst_ff);
         prod_b_ff <= PROD_W'(keep) * PROD_W'(ewma_ff[EWMA_W-1:FRAC_W]);
         prod_c_ff <= PROD_LO_W'(keep) * PROD_LO_W'(ewma_ff[FRAC_W-1:0]);
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_ff.accepted    <= !neg_ff;
         rsp_ff.inst_rate   <= inst_ff;
         rsp_ff.window_rate <= win_rate_ff;
         rsp_ff.ewma_rate   <= ewma_ff[EWMA_W-1:FRAC_W];
         rsp_ff.peak_rate   <= peak_ff;
         rsp_ff.byte_total  <= total_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   brt_cell_row u_row (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (row_ctrl),
      .delta    (delta),
      .tap      (tap),
      .head_sum (head_sum),
      .tap_sum  (tap_sum)
   );

   brt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({tap_sum, 3'b000}),
      .divisor  (win_eff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   `BRT_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE, "stray result")
   `BRT_ASSERT(a_peak_covers_window, peak_ff >= win_rate_ff, "peak below window rate")
   `BRT_ASSERT(a_head_bucket_bounded, head_sum <= SUM_W'(BUCKET_MAX), "bucket above max")
   `BRT_ASSERT_ALWAYS(a_idle_divider_free, (state_ff == ST_IDLE) |-> !div_busy, "busy while idle")

endmodule

// File: design/brt_cell.sv
// one cell of the bucket row: prefix sum of the newest buckets up to this age
module brt_cell import brt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  row_ctrl_type        ctrl,
   input  logic [BUCKET_W-1:0] delta,
   input  logic [SUM_W-1:0]    prev_sum,
   output logic [SUM_W-1:0]    sum
);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.shift) begin
         sum_in = prev_sum;
      end else if (ctrl.add) begin
         sum_in = sum_ff + SUM_W'(delta);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: design/brt_cell_row.sv
// row of prefix-sum cells, newest second first, with a registered window tap
module brt_cell_row import brt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  row_ctrl_type        ctrl,
   input  logic [BUCKET_W-1:0] delta,
   input  logic [PTR_W-1:0]    tap,
   output logic [SUM_W-1:0]    head_sum,
   output logic [SUM_W-1:0]    tap_sum
);

   logic [SUM_W-1:0] cell_sum [BUCKETS];
   logic [SUM_W-1:0] tap_sum_ff;

   genvar k;
   generate
      for (k = 0; k < BUCKETS; k++) begin : g_cell
         logic [SUM_W-1:0] prev;
         if (k == 0) begin : g_head
            assign prev = '0;
         end else begin : g_body
            assign prev = cell_sum[k-1];
         end
         brt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .delta    (delta),
            .prev_sum (prev),
            .sum      (cell_sum[k])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      tap_sum_ff <= cell_sum[tap];
   end

   assign head_sum = cell_sum[0];
   assign tap_sum  = tap_sum_ff;

endmodule

// File: design/brt_divider.sv
// restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module brt_divider import brt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_N-1:0] dividend,
   input  logic [WIN_W-1:0] divisor,
   output logic             busy,
   output logic [DIV_N-1:0] quotient
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [WIN_W-1:0]     rem_ff;
   logic [DIV_N-1:0]     quo_ff;
   logic [WIN_W-1:0]     div_ff;
   logic [WIN_W:0]       partial;
   logic [WIN_W:0]       diff;
   logic                 fits;

   always_comb begin
      partial = {rem_ff, quo_ff[DIV_N-1]};
      diff    = partial - {1'b0, div_ff};
      fits    = (partial >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(DIV_N);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_N-2:0], fits};
         rem_ff <= fits ? diff[WIN_W-1:0] : partial[WIN_W-1:0];
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   `BRT_ASSERT(a_busy_from_start, $rose(busy_ff) |-> $past(start), "divider went busy without start")

endmodule

// File: tb/tb_byte_rate_tracker_core.sv
// self-checking testbench for the byte rate tracker core with a built-in rate predictor
module tb_byte_rate_tracker_core;
   import brt_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 8;
   localparam int LIMIT_CYCLES  = 3_000_000;
   localparam int IDLE_PERCENT  = 23;
   localparam int SETTLE_CYCLES = 130;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_LIMIT   = 40;
   localparam logic [63:0] Q16_ONE = 64'd1 << FRAC_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
   localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = REG_WINDOW;
   logic [CSR_DATA_W-1:0] csr_data    = '0;

   byte_rate_tracker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // predictor state
   logic [BUCKET_W-1:0] ring [BUCKETS];
   logic [PTR_W-1:0]    ring_ptr;
   logic [SECOND_W-1:0] ring_second;
   logic [TOTAL_W-1:0]  meter_total;
   logic [RATE_W-1:0]   meter_inst;
   logic [RATE_W-1:0]   meter_window;
   logic [RATE_W-1:0]   meter_peak;
   logic [63:0]         meter_ewma;
   logic [WIN_W-1:0]    window_cfg;
   logic [ALPHA_W-1:0]  alpha_cfg;

   rsp_type expected_rates[$];
   int      errors       = 0;
   bit      steady       = 1'b0;
   int      hold_request = 0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(64'(LIMIT_CYCLES) * CLOCK_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= PRINT_LIMIT) begin
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      end
   endtask

   task automatic meter_reset();
      for (int k = 0; k < BUCKETS; k++) ring[k] = '0;
      ring_ptr     = '0;
      ring_second  = '0;
      meter_total  = '0;
      meter_inst   = '0;
      meter_window = '0;
      meter_peak   = '0;
      meter_ewma   = '0;
      window_cfg   = WINDOW_RESET;
      alpha_cfg    = ALPHA_RESET;
   endtask

   task automatic predict_rates(input req_type ev);
      logic [63:0]         bytes;
      logic [63:0]         sum;
      logic [63:0]         div;
      logic [63:0]         alpha;
      logic [63:0]         keep;
      logic [63:0]         hi;
      logic [63:0]         lo;
      logic [SECOND_W-1:0] now;
      int                  span;
      int                  lim;
      rsp_type             r;
      r.accepted = !ev.byte_count[COUNT_W-1];
      if (r.accepted) begin
         bytes = 64'(ev.byte_count[COUNT_W-2:0]);
         now   = ev.now_second;
         if (64'(meter_total) > 64'(TOTAL_MAX) - bytes) begin
            meter_total = TOTAL_MAX;
         end else begin
            meter_total = meter_total + TOTAL_W'(bytes);
         end
         if (now != ring_second) begin
            if (now < ring_second || 64'(now - ring_second) >= 64'(BUCKETS)) begin
               for (int k = 0; k < BUCKETS; k++) ring[k] = '0;
            end else begin
               span = int'(now - ring_second);
               for (int k = 0; k < span; k++) begin
                  ring_ptr       = PTR_W'((int'(ring_ptr) + 1) % BUCKETS);
                  ring[ring_ptr] = '0;
               end
            end
            ring_second = now;
         end
         if (64'(ring[ring_ptr]) > 64'(BUCKET_MAX) - bytes) begin
            ring[ring_ptr] = BUCKET_MAX;
         end else begin
            ring[ring_ptr] = ring[ring_ptr] + BUCKET_W'(bytes);
         end
         meter_inst = RATE_W'(64'(ring[ring_ptr]) * 8);
         div = (window_cfg == '0) ? 64'd1 : 64'(window_cfg);
         lim = (div > 64'(BUCKETS)) ? BUCKETS : int'(div);
         sum = '0;
         for (int k = 0; k < lim; k++) begin
            sum = sum + 64'(ring[(int'(ring_ptr) + BUCKETS - k) % BUCKETS]);
         end
         meter_window = RATE_W'((sum * 8) / div);
         alpha = (64'(alpha_cfg) > Q16_ONE) ? Q16_ONE : 64'(alpha_cfg);
         keep  = Q16_ONE - alpha;
         hi    = meter_ewma >> FRAC_W;
         lo    = meter_ewma & (Q16_ONE - 1);
         meter_ewma = alpha * 64'(meter_inst) + keep * hi + ((keep * lo) >> FRAC_W);
         if (meter_window > meter_peak) meter_peak = meter_window;
      end
      r.inst_rate   = meter_inst;
      r.window_rate = meter_window;
      r.ewma_rate   = RATE_W'(meter_ewma >> FRAC_W);
      r.peak_rate   = meter_peak;
      r.byte_total  = meter_total;
      expected_rates.push_back(r);
   endtask

   // one transaction on the event channel; valid stays up for a back-to-back follow-up
   task automatic send_event(input logic [COUNT_W-1:0] count, input logic [SECOND_W-1:0] now);
      req_type ev;
      ev.byte_count = count;
      ev.now_second = now;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      do @(posedge clock); while (req_stall);
      predict_rates(ev);
   endtask

   task automatic wait_quiet(input int extra);
      req_valid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_quiet(4);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WINDOW) begin
         window_cfg = value[WIN_W-1:0];
      end else if (idx == REG_ALPHA) begin
         alpha_cfg = value[ALPHA_W-1:0];
      end
   endtask

   function automatic logic [COUNT_W-1:0] random_count();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return {1'b1, (COUNT_W-1)'($urandom)};
      if (pick < 20) return '0;
      if (pick < 40) return COUNT_W'($urandom_range(1000));
      if (pick < 70) return COUNT_W'($urandom_range(1 << 20));
      if (pick < 92) return {1'b0, (COUNT_W-1)'($urandom)};
      return COUNT_MAX;
   endfunction

   function automatic logic [SECOND_W-1:0] next_second(input logic [SECOND_W-1:0] prev);
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return prev;
      if (pick < 70) return prev + 1;
      if (pick < 85) return prev + $urandom_range(2, 10);
      if (pick < 92) return prev + $urandom_range(11, BUCKETS - 1);
      if (pick < 95) return prev + $urandom_range(BUCKETS, 300);
      if (pick < 98) return prev - $urandom_range(1, 100);
      return $urandom;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_window();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return '0;
      if (pick < 30) return CSR_DATA_W'({WIN_W{1'b1}});
      if (pick < 40) return CSR_DATA_W'(BUCKETS);
      return CSR_DATA_W'($urandom_range(1, (1 << WIN_W) - 1));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_alpha();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return '0;
      if (pick < 30) return ALPHA_ONE;
      if (pick < 40) return {ALPHA_W{1'b1}};
      return CSR_DATA_W'($urandom_range(0, (1 << ALPHA_W) - 1));
   endfunction

   task automatic test_directed_cases();
      send_event('0, 0);
      send_event(COUNT_MAX, 0);
      send_event('1, 0);
      send_event(COUNT_MIN, 0);
      send_event(100, 1);
      send_event(COUNT_MAX, 2);
      send_event(5, 2 + BUCKETS - 1);
      send_event(7, 2 + 2 * BUCKETS - 1);
      send_event(3, 100);
      send_event(9, {SECOND_W{1'b1}});
      send_event(1, 0);
      send_event('0, 0);
   endtask

   task automatic test_window_settings();
      logic [CSR_DATA_W-1:0] widths [7];
      logic [SECOND_W-1:0]   now;
      widths = '{'0, CSR_DATA_W'(BUCKETS), CSR_DATA_W'({WIN_W{1'b1}}), 1, 2,
                 CSR_DATA_W'(BUCKETS + 1), random_window()};
      now = $urandom;
      foreach (widths[i]) begin
         write_register(REG_WINDOW, widths[i]);
         for (int k = 0; k < 12; k++) begin
            now = now + $urandom_range(0, 1);
            send_event(random_count(), now);
         end
      end
   endtask

   task automatic test_alpha_settings();
      logic [CSR_DATA_W-1:0] alphas [6];
      logic [SECOND_W-1:0]   now;
      alphas = '{'0, ALPHA_ONE, {ALPHA_W{1'b1}}, ALPHA_ONE - 1, 1, random_alpha()};
      now = $urandom;
      write_register(REG_WINDOW, 4);
      foreach (alphas[i]) begin
         write_register(REG_ALPHA, alphas[i]);
         for (int k = 0; k < 10; k++) begin
            now = now + $urandom_range(0, 1);
            send_event(random_count(), now);
         end
      end
      write_register(REG_ALPHA, ALPHA_RESET);
   endtask

   // enough near-maximum counts in one second to pin the bucket at its ceiling
   task automatic test_bucket_saturation();
      logic [SECOND_W-1:0] now;
      now = $urandom;
      write_register(REG_WINDOW, BUCKETS);
      for (int k = 0; k < 540; k++) begin
         send_event(COUNT_MAX - COUNT_W'($urandom_range(1 << 16)), now);
      end
      send_event(COUNT_MAX, now + 1);
      send_event(COUNT_MAX, now + 1);
   endtask

   task automatic test_random_traffic();
      logic [SECOND_W-1:0] now;
      now = $urandom;
      for (int phase = 0; phase < 8; phase++) begin
         write_register(REG_WINDOW, random_window());
         write_register(REG_ALPHA, random_alpha());
         steady = (phase == 3);
         for (int k = 0; k < 140; k++) begin
            now = next_second(now);
            send_event(random_count(), now);
         end
         wait_quiet(1);
         steady = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      logic [SECOND_W-1:0] now;
      now = $urandom;
      write_register(REG_WINDOW, 8);
      hold_request = HOLD_CYCLES;
      for (int k = 0; k < 6; k++) begin
         now = now + 1;
         send_event(random_count(), now);
      end
      wait_quiet(1);
      for (int k = 0; k < 6; k++) begin
         now = next_second(now);
         send_event(random_count(), now);
      end
   endtask

   // receiver: random stall, or a long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rates.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_payload.byte_total), '0);
         end else begin
            want = expected_rates.pop_front();
            if (rsp_payload.accepted !== want.accepted)
               report_mismatch("accepted", 64'(rsp_payload.accepted), 64'(want.accepted));
            if (rsp_payload.inst_rate !== want.inst_rate)
               report_mismatch("inst_rate", 64'(rsp_payload.inst_rate), 64'(want.inst_rate));
            if (rsp_payload.window_rate !== want.window_rate)
               report_mismatch("window_rate", 64'(rsp_payload.window_rate),
                               64'(want.window_rate));
            if (rsp_payload.ewma_rate !== want.ewma_rate)
               report_mismatch("ewma_rate", 64'(rsp_payload.ewma_rate), 64'(want.ewma_rate));
            if (rsp_payload.peak_rate !== want.peak_rate)
               report_mismatch("peak_rate", 64'(rsp_payload.peak_rate), 64'(want.peak_rate));
            if (rsp_payload.byte_total !== want.byte_total)
               report_mismatch("byte_total", 64'(rsp_payload.byte_total),
                               64'(want.byte_total));
         end
      end
   end

   initial begin
      meter_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_window_settings();
      test_alpha_settings();
      test_bucket_saturation();
      test_random_traffic();
      test_backpressure();
      wait_quiet(SETTLE_CYCLES);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/brt_pkg.sv
design/brt_cell.sv
design/brt_cell_row.sv
design/brt_divider.sv
design/byte_rate_tracker_core.sv
tb/tb_byte_rate_tracker_core.sv
